@@ src/fscp_pkg.sv @@
package fscp_pkg;

  localparam int MAX_FRAME_BYTES = 10;
  localparam int COUNT_W = $clog2(MAX_FRAME_BYTES);

  localparam logic [7:0] CH_START = 8'h21;  // '!'
  localparam logic [7:0] CH_END   = 8'h23;  // '#'
  localparam logic [7:0] CH_X     = 8'h58;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;

  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [1:0] ACT_SET      = 2'd0;
  localparam logic [1:0] ACT_CLEAR    = 2'd1;
  localparam logic [1:0] ACT_SETPOINT = 2'd2;
  localparam logic [1:0] ACT_ERROR    = 2'd3;

  localparam logic [1:0] TGT_PUMP  = 2'd0;
  localparam logic [1:0] TGT_LIGHT = 2'd1;
  localparam logic [1:0] TGT_TEMP  = 2'd2;
  localparam logic [1:0] TGT_HUMID = 2'd3;

  typedef struct packed {
    logic [1:0]  action;
    logic [1:0]  target;
    logic [15:0] value;
  } result_t;

endpackage

@@ src/fscp_decode.sv @@
module fscp_decode import fscp_pkg::*; (
  input  logic [7:0]  command_letter,
  input  logic [7:0]  target_letter,
  input  logic        clear_marker_seen,
  input  logic [15:0] value_accumulator,
  output result_t     result
);

  always_comb begin
    result = '{action: ACT_ERROR, target: TGT_PUMP, value: 16'd0};
    if (command_letter == CH_D && target_letter == CH_P) begin
      if (clear_marker_seen) begin
        result = '{action: ACT_CLEAR, target: TGT_PUMP, value: 16'd0};
      end else begin
        result = '{action: ACT_SET, target: TGT_PUMP, value: value_accumulator};
      end
    end else if (command_letter == CH_S) begin
      priority if (target_letter == CH_L) begin
        result = '{action: ACT_SETPOINT, target: TGT_LIGHT, value: value_accumulator};
      end else if (target_letter == CH_T) begin
        result = '{action: ACT_SETPOINT, target: TGT_TEMP, value: value_accumulator};
      end else if (target_letter == CH_H) begin
        result = '{action: ACT_SETPOINT, target: TGT_HUMID, value: value_accumulator};
      end else begin
        result = '{action: ACT_ERROR, target: TGT_PUMP, value: 16'd0};
      end
    end
  end

endmodule

@@ src/framed_serial_command_parser.sv @@
// A result appears on the master side in the cycle after the closing '#' is taken.
// Throughput: one byte or tick per cycle while no result is stalled; frame registers update
// in the accepting cycle and the output register frees itself in the same cycle it is read.
// Reset (rst, synchronous, active high): no frame open, counters and letters cleared,
// output empty, timeout_ticks back to 1000.
module framed_serial_command_parser import fscp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,       // timeout_ticks
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic [0:0]  s_axis_tuser,   // [0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] value
  output logic [3:0]  m_axis_tuser    // [1:0] action, [3:2] target
);

  logic [15:0]        timeout_ticks;
  logic               collecting, collecting_next;
  logic [COUNT_W-1:0] byte_count, byte_count_next;
  logic [7:0]         command_letter, command_letter_next;
  logic [7:0]         target_letter, target_letter_next;
  logic               clear_marker_seen, clear_marker_seen_next;
  logic [15:0]        value_accumulator, value_accumulator_next;
  logic [15:0]        idle_tick_count, idle_tick_count_next;
  logic               emit;
  logic               in_xact;
  logic [COUNT_W:0]   count_plus;
  logic [15:0]        digit;
  result_t            decoded;
  result_t            result;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_xact       = s_axis_tvalid && s_axis_tready;

  assign count_plus = {1'b0, byte_count} + {{COUNT_W{1'b0}}, 1'b1};
  assign digit      = {8'd0, s_axis_tdata - CH_0};

  fscp_decode u_decode (
    .command_letter    (command_letter),
    .target_letter     (target_letter),
    .clear_marker_seen (clear_marker_seen),
    .value_accumulator (value_accumulator),
    .result            (decoded)
  );

  always_comb begin
    collecting_next        = collecting;
    byte_count_next        = byte_count;
    command_letter_next    = command_letter;
    target_letter_next     = target_letter;
    clear_marker_seen_next = clear_marker_seen;
    value_accumulator_next = value_accumulator;
    idle_tick_count_next   = idle_tick_count;
    emit                   = 1'b0;
    if (!collecting) begin
      if (s_axis_tuser[0] == OP_BYTE && s_axis_tdata == CH_START) begin
        collecting_next        = 1'b1;
        byte_count_next        = COUNT_W'(1);
        command_letter_next    = 8'd0;
        target_letter_next     = 8'd0;
        clear_marker_seen_next = 1'b0;
        value_accumulator_next = 16'd0;
        idle_tick_count_next   = 16'd0;
      end
    end else if (s_axis_tuser[0] == OP_TICK) begin
      // saturate the idle count, then drop on timeout
      if (idle_tick_count != 16'hFFFF) begin
        idle_tick_count_next = idle_tick_count + 16'd1;
      end
      if (idle_tick_count_next >= timeout_ticks) begin
        collecting_next = 1'b0;
        byte_count_next = '0;
      end
    end else begin
      idle_tick_count_next = 16'd0;
      if (s_axis_tdata == CH_END) begin
        emit            = 1'b1;
        collecting_next = 1'b0;
        byte_count_next = '0;
      end else begin
        if (byte_count == COUNT_W'(1)) begin
          command_letter_next = s_axis_tdata;
        end else if (byte_count == COUNT_W'(2)) begin
          target_letter_next = s_axis_tdata;
        end else begin
          if (byte_count == COUNT_W'(3) && s_axis_tdata == CH_X) begin
            clear_marker_seen_next = 1'b1;
          end
          if (s_axis_tdata >= CH_0 && s_axis_tdata <= CH_9) begin
            // acc * 10 as (acc << 3) + (acc << 1), modulo 2^16
            value_accumulator_next = (value_accumulator << 3) + (value_accumulator << 1)
                                     + digit;
          end
        end
        if (count_plus >= (COUNT_W+1)'(MAX_FRAME_BYTES)) begin
          collecting_next = 1'b0;
          byte_count_next = '0;
        end else begin
          byte_count_next = count_plus[COUNT_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks     <= TIMEOUT_RESET;
      collecting        <= 1'b0;
      byte_count        <= '0;
      command_letter    <= 8'd0;
      target_letter     <= 8'd0;
      clear_marker_seen <= 1'b0;
      value_accumulator <= 16'd0;
      idle_tick_count   <= 16'd0;
      m_axis_tvalid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        timeout_ticks <= cfg_data;
      end
      if (in_xact) begin
        collecting        <= collecting_next;
        byte_count        <= byte_count_next;
        command_letter    <= command_letter_next;
        target_letter     <= target_letter_next;
        clear_marker_seen <= clear_marker_seen_next;
        value_accumulator <= value_accumulator_next;
        idle_tick_count   <= idle_tick_count_next;
      end
      if (in_xact && emit) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // hold the result payload until the next emitted transaction
  always_ff @(posedge clk) begin
    if (in_xact && emit) begin
      result <= decoded;
    end
  end

  assign m_axis_tdata = result.value;
  assign m_axis_tuser = {result.target, result.action};

endmodule

@@ src/fscp_checker.sv @@
module fscp_checker import fscp_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [3:0]  m_axis_tuser
);

  // a stalled result stays in place
  property p_out_hold;
    @(posedge clk) disable iff (rst)
      m_axis_tvalid && !m_axis_tready |=>
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser);
  endproperty
  a_out_hold: assert property (p_out_hold) else $error("result changed while stalled");

  property p_ready_when_empty;
    @(posedge clk) disable iff (rst) !m_axis_tvalid |-> s_axis_tready;
  endproperty
  a_ready_when_empty: assert property (p_ready_when_empty)
    else $error("input stalled with empty output");

  property p_error_zero;
    @(posedge clk) disable iff (rst)
      m_axis_tvalid && (m_axis_tuser[1:0] == ACT_ERROR || m_axis_tuser[1:0] == ACT_CLEAR) |->
        m_axis_tuser[3:2] == TGT_PUMP && m_axis_tdata == 16'd0;
  endproperty
  a_error_zero: assert property (p_error_zero)
    else $error("error or clear result carries target or value");

  property p_setpoint_target;
    @(posedge clk) disable iff (rst)
      m_axis_tvalid && m_axis_tuser[1:0] == ACT_SETPOINT |-> m_axis_tuser[3:2] != TGT_PUMP;
  endproperty
  a_setpoint_target: assert property (p_setpoint_target)
    else $error("setpoint result aimed at pump");

  property p_set_target;
    @(posedge clk) disable iff (rst)
      m_axis_tvalid && m_axis_tuser[1:0] == ACT_SET |-> m_axis_tuser[3:2] == TGT_PUMP;
  endproperty
  a_set_target: assert property (p_set_target) else $error("set result not aimed at pump");

endmodule

bind framed_serial_command_parser fscp_checker u_fscp_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

@@ bench/framed_serial_command_parser_tb.sv @@
module framed_serial_command_parser_tb;
  import fscp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic        op;
    logic [15:0] data;      // byte in [7:0], or timeout_ticks for ROW_CFG
    logic        typed;
    result_t     res;
  } row_t;

  localparam result_t NO_RESULT = '0;

  localparam row_t DIRECTED_ROWS [29] = '{
    // idle: ticks and stray bytes are ignored
    '{ROW_ITEM, OP_TICK, 16'h00FF, 1'b0, NO_RESULT},
    '{ROW_ITEM, OP_BYTE, 16'h0000, 1'b0, NO_RESULT},
    // short pump frame, no digits
    '{ROW_ITEM, OP_BYTE, {8'h00, CH_START}, 1'b0, NO_RESULT},
    '{ROW_ITEM, OP_BYTE, {8'h00, CH_D}, 1'b0, NO_RESULT},
    '{ROW_ITEM, OP_BYTE, {8'h00, CH_P}, 1'b0, NO_RESULT},
    '{ROW_ITEM, OP_BYTE, {8'h00, CH_END}, 1'b1, {ACT_SET, TGT_PUMP, 16'd0}},
    // clear remote control
    '{ROW_ITEM, OP_BYTE, {8'h00, CH_START}, 1'b0, NO_RESULT},
    '{ROW_ITEM, OP_BYTE, {8'h00, CH_D}, 1'b0, NO_RESULT},
    '{ROW_ITEM, OP_BYTE, {8'h00, CH_P}, 1'b0, NO_RESULT},
    '{ROW_ITEM, OP_BYTE, {8'h00, CH_X}, 1'b0, NO_RESULT},
    '{ROW_ITEM, OP_BYTE, {8'h00, CH_END}, 1'b1, {ACT_CLEAR, TGT_PUMP, 16'd0}},
    // setpoint with a non-digit skipped
    '{ROW_ITEM, OP_BYTE, {8'h00, CH_START}, 1'b0, NO_RESULT},
    '{ROW_ITEM, OP_BYTE, {8'h00, CH_S}, 1'b0, NO_RESULT},
    '{ROW_ITEM, OP_BYTE, {8'h00, CH_H}, 1'b0, NO_RESULT},
    '{ROW_ITEM, OP_BYTE, 16'h00FF, 1'b0, NO_RESULT},
    '{ROW_ITEM, OP_BYTE, {8'h00, CH_9}, 1'b0, NO_RESULT},
    '{ROW_ITEM, OP_BYTE, {8'h00, CH_END}, 1'b1, {ACT_SETPOINT, TGT_HUMID, 16'd9}},
    // '!' as target inside an open frame
    '{ROW_ITEM, OP_BYTE, {8'h00, CH_START}, 1'b0, NO_RESULT},
    '{ROW_ITEM, OP_BYTE, {8'h00, CH_S}, 1'b0, NO_RESULT},
    '{ROW_ITEM, OP_BYTE, {8'h00, CH_START}, 1'b0, NO_RESULT},
    '{ROW_ITEM, OP_BYTE, {8'h00, CH_END}, 1'b1, {ACT_ERROR, TGT_PUMP, 16'd0}},
    // pump command with a bad target
    '{ROW_ITEM, OP_BYTE, {8'h00, CH_START}, 1'b0, NO_RESULT},
    '{ROW_ITEM, OP_BYTE, {8'h00, CH_D}, 1'b0, NO_RESULT},
    '{ROW_ITEM, OP_BYTE, 16'h0000, 1'b0, NO_RESULT},
    '{ROW_ITEM, OP_BYTE, {8'h00, CH_END}, 1'b1, {ACT_ERROR, TGT_PUMP, 16'd0}},
    // shortest timeout: one tick drops the open frame
    '{ROW_CFG,  OP_BYTE, 16'd1, 1'b0, NO_RESULT},
    '{ROW_ITEM, OP_BYTE, {8'h00, CH_START}, 1'b0, NO_RESULT},
    '{ROW_ITEM, OP_BYTE, {8'h00, CH_S}, 1'b0, NO_RESULT},
    '{ROW_ITEM, OP_TICK, 16'h0000, 1'b0, NO_RESULT}
  };

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic [0:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic [3:0]  m_axis_tuser;

  framed_serial_command_parser u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // parser state as the testbench sees it
  logic        frame_open  = 1'b0;
  int          frame_len   = 0;
  logic [7:0]  cmd_letter  = '0;
  logic [7:0]  tgt_letter  = '0;
  logic        clear_seen  = 1'b0;
  logic [15:0] arg_value   = '0;
  logic [15:0] idle_ticks  = '0;
  logic [15:0] timeout_cfg = TIMEOUT_RESET;

  result_t expected_commands[$];
  int      bad_results   = 0;
  int      commands_seen = 0;
  int      items_sent    = 0;
  int      burst_left    = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Returns 1 when the byte closes a frame; cmd then holds the decoded command.
  function automatic bit parse_step(input logic op, input logic [7:0] b, output result_t cmd);
    cmd = '0;
    if (!frame_open) begin
      if (op == OP_BYTE && b == CH_START) begin
        frame_open = 1'b1;
        frame_len  = 1;
        cmd_letter = '0;
        tgt_letter = '0;
        clear_seen = 1'b0;
        arg_value  = '0;
        idle_ticks = '0;
      end
      return 1'b0;
    end
    if (op == OP_TICK) begin
      if (idle_ticks != 16'hFFFF) idle_ticks++;
      if (idle_ticks >= timeout_cfg) frame_open = 1'b0;
      return 1'b0;
    end
    idle_ticks = '0;
    if (b == CH_END) begin
      frame_open = 1'b0;
      if (cmd_letter == CH_D && tgt_letter == CH_P) begin
        cmd.action = clear_seen ? ACT_CLEAR : ACT_SET;
        cmd.target = TGT_PUMP;
        cmd.value  = clear_seen ? 16'd0 : arg_value;
      end else if (cmd_letter == CH_S &&
                   (tgt_letter == CH_L || tgt_letter == CH_T || tgt_letter == CH_H)) begin
        cmd.action = ACT_SETPOINT;
        cmd.value  = arg_value;
        case (tgt_letter)
          CH_L: cmd.target = TGT_LIGHT;
          CH_T: cmd.target = TGT_TEMP;
          default: cmd.target = TGT_HUMID;
        endcase
      end else begin
        cmd.action = ACT_ERROR;
      end
      return 1'b1;
    end
    case (frame_len)
      1: cmd_letter = b;
      2: tgt_letter = b;
      default: begin
        if (frame_len == 3 && b == CH_X) clear_seen = 1'b1;
        if (b >= CH_0 && b <= CH_9) arg_value = arg_value * 16'd10 + 16'(b - CH_0);
      end
    endcase
    if (frame_len + 1 >= MAX_FRAME_BYTES) frame_open = 1'b0;
    else frame_len++;
    return 1'b0;
  endfunction

  task automatic send_item(input logic op, input logic [7:0] b, input logic typed,
                           input result_t typed_res);
    int      gap;
    result_t cmd;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                               : $urandom_range(1, 16);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= op;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    burst_left--;
    items_sent++;
    if (parse_step(op, b, cmd) || typed)
      expected_commands.push_back(typed ? typed_res : cmd);
  endtask

  // Some bytes of a frame are preceded by ticks; with small timeouts they may drop it.
  task automatic send_frame_byte(input logic [7:0] b);
    int n;
    if ($urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, (int'(timeout_cfg) <= 8) ? int'(timeout_cfg) : 4);
      repeat (n) send_item(OP_TICK, 8'($urandom_range(0, 255)), 1'b0, NO_RESULT);
    end
    send_item(OP_BYTE, b, 1'b0, NO_RESULT);
  endtask

  task automatic send_frame();
    logic [7:0] cmd_b;
    logic [7:0] tgt_b;
    logic [7:0] arg;
    int         pick;
    int         letters;
    int         n_args;
    pick = $urandom_range(0, 9);
    if (pick < 4) cmd_b = CH_D;
    else if (pick < 8) cmd_b = CH_S;
    else cmd_b = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 7);
    if (cmd_b == CH_D) begin
      tgt_b = (pick < 6) ? CH_P : 8'($urandom_range(0, 255));
    end else begin
      case (pick)
        0, 1: tgt_b = CH_L;
        2, 3: tgt_b = CH_T;
        4, 5: tgt_b = CH_H;
        default: tgt_b = 8'($urandom_range(0, 255));
      endcase
    end
    letters = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 1) : 2;
    if (letters < 2) n_args = 0;
    else if ($urandom_range(0, 9) == 0) n_args = $urandom_range(7, 9);
    else n_args = $urandom_range(0, 6);
    send_item(OP_BYTE, CH_START, 1'b0, NO_RESULT);
    if (letters > 0) send_frame_byte(cmd_b);
    if (letters > 1) send_frame_byte(tgt_b);
    for (int i = 0; i < n_args; i++) begin
      if (i == 0 && cmd_b == CH_D && $urandom_range(0, 3) == 0) arg = CH_X;
      else if ($urandom_range(0, 9) == 0) arg = 8'($urandom_range(0, 255));
      else arg = 8'($urandom_range(CH_0, CH_9));
      send_frame_byte(arg);
    end
    send_frame_byte(CH_END);
  endtask

  // Hold the input until every command is out, then let the pipeline settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_commands.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [15:0] ticks);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= ticks;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid   <= 1'b0;
    timeout_cfg = ticks;
  endtask

  initial begin : receiver
    logic long_stall_done;
    long_stall_done = 1'b0;
    m_axis_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!long_stall_done && commands_seen >= 40 && s_axis_tvalid) begin
        // long hold-off while the sender keeps offering
        long_stall_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end else begin
        case ($urandom_range(0, 3))
          0: begin
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(20, 60)) @(posedge clk);
          end
          1: begin
            m_axis_tready <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge clk);
          end
          default: begin
            repeat ($urandom_range(5, 20)) begin
              m_axis_tready <= ($urandom_range(0, 2) != 0);
              @(posedge clk);
            end
          end
        endcase
      end
    end
  end

  always @(posedge clk) begin : command_check
    result_t got;
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.action = m_axis_tuser[1:0];
      got.target = m_axis_tuser[3:2];
      got.value  = m_axis_tdata;
      commands_seen++;
      if (expected_commands.size() == 0) begin
        bad_results++;
        if (bad_results <= 10)
          $display("%0t: unexpected command action=%0d target=%0d value=%0d",
                   $realtime, got.action, got.target, got.value);
      end else begin
        want = expected_commands.pop_front();
        if (got.action !== want.action || got.target !== want.target ||
            got.value !== want.value) begin
          bad_results++;
          if (bad_results <= 10)
            $display("%0t: mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                     $realtime, want.action, want.target, want.value,
                     got.action, got.target, got.value);
        end
      end
    end
  end

  initial begin : stimulus
    logic [15:0] ticks;
    int          goal;
    int          pick;
    rst           <= 1'b1;
    cfg_valid     <= 1'b0;
    cfg_data      <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= OP_BYTE;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED_ROWS[i]) begin
      if (DIRECTED_ROWS[i].kind == ROW_CFG)
        write_timeout(DIRECTED_ROWS[i].data);
      else
        send_item(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].data[7:0],
                  DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].res);
    end

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: ticks = TIMEOUT_RESET;
        1: ticks = 16'd65535;
        2: ticks = 16'd1;
        3: ticks = 16'd3;
        default: ticks = 16'($urandom_range(2, 12));
      endcase
      write_timeout(ticks);
      if (ph == 3) begin
        // one tick short of the timeout keeps the frame, the full count drops it
        for (int n = int'(ticks) - 1; n <= int'(ticks); n++) begin
          send_item(OP_BYTE, CH_START, 1'b0, NO_RESULT);
          send_item(OP_BYTE, CH_S, 1'b0, NO_RESULT);
          send_item(OP_BYTE, CH_L, 1'b0, NO_RESULT);
          repeat (n) send_item(OP_TICK, 8'($urandom_range(0, 255)), 1'b0, NO_RESULT);
          send_item(OP_BYTE, 8'(CH_0 + 5), 1'b0, NO_RESULT);
          send_item(OP_BYTE, CH_END, 1'b0, NO_RESULT);
        end
      end
      goal = items_sent + 215;
      while (items_sent < goal) begin
        pick = $urandom_range(0, 19);
        if (pick < 2) begin
          repeat ($urandom_range(1, 4))
            send_item(logic'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b0, NO_RESULT);
        end else if (pick == 2) begin
          drain();
        end else begin
          send_frame();
        end
      end
    end

    drain();
    if (bad_results == 0 && expected_commands.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
